/* src/csre_pkg.sv */
// shared types and constants for the seed ring energy sum unit
package csre_pkg;

  localparam int ETA_W    = 7;
  localparam int PHI_W    = 8;
  localparam int EN_W     = 20;
  localparam int RN_W     = 5;
  localparam int SUM_W    = 30;
  localparam int CNT_W    = 11;
  localparam int DIST_W   = PHI_W;
  localparam int PHI_BINS = 256;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [RN_W-1:0]  RING_COUNT_RST = 5'd30;

  // register index as decoded from paddr
  localparam logic REG_RING_COUNT = 1'b0;

  typedef struct packed {
    logic [ETA_W-1:0] eta;
    logic [PHI_W-1:0] phi;
    logic [EN_W-1:0]  energy;
  } tower_t;

  typedef struct packed {
    logic [SUM_W-1:0] energy;
    logic [CNT_W-1:0] count;
  } acc_t;

  typedef struct packed {
    logic clear;
    logic twr_v;
    logic rd_en;
  } acc_ctl_t;

endpackage

/* src/csre_if.sv */
// request channel interfaces for towers and ring results
interface csre_in_if;
  logic                      valid;
  logic                      ready;
  logic [csre_pkg::ETA_W-1:0] eta_index;
  logic [csre_pkg::PHI_W-1:0] phi_index;
  logic [csre_pkg::EN_W-1:0]  tower_energy;
  logic                      is_last;

  modport source (output valid, eta_index, phi_index, tower_energy, is_last, input ready);
  modport sink (input valid, eta_index, phi_index, tower_energy, is_last, output ready);
endinterface

interface csre_out_if;
  logic                       valid;
  logic                       ready;
  logic [csre_pkg::RN_W-1:0]  ring_number;
  logic [csre_pkg::SUM_W-1:0] ring_energy;
  logic [csre_pkg::SUM_W-1:0] square_energy;
  logic [csre_pkg::CNT_W-1:0] towers_in_ring;
  logic                       seed_found;
  logic                       last_ring;

  modport source (output valid, ring_number, ring_energy, square_energy, towers_in_ring,
                  seed_found, last_ring, input ready);
  modport sink (input valid, ring_number, ring_energy, square_energy, towers_in_ring,
                seed_found, last_ring, output ready);
endinterface

/* src/csre_ram.sv */
// generic single write port ram with registered read
module csre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/csre_apb_regs.sv */
// apb configuration register for the ring count
module csre_apb_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [csre_pkg::CFG_AW-1:0] paddr,
  input  logic [csre_pkg::CFG_DW-1:0] pwdata,
  output logic [csre_pkg::CFG_DW-1:0] prdata,
  output logic                        pready,
  output logic [csre_pkg::RN_W-1:0]   ring_count
);
  import csre_pkg::*;

  logic [RN_W-1:0] ring_count_r;
  logic            sel_rc;

  assign sel_rc = (paddr[CFG_AW-1] == REG_RING_COUNT);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_count_r <= RING_COUNT_RST;
    end else if (psel && penable && pwrite && sel_rc) begin
      ring_count_r <= pwdata[RN_W-1:0];
    end
  end

  assign prdata     = sel_rc ? CFG_DW'(ring_count_r) : '0;
  assign ring_count = ring_count_r;

endmodule

/* src/csre_ring_acc.sv */
// ring distance and read-modify-write of the ring accumulator memory
module csre_ring_acc #(
  parameter int MAX_RINGS = 30,
  parameter int RIW       = (MAX_RINGS > 1) ? $clog2(MAX_RINGS) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  csre_pkg::acc_ctl_t        ctl,
  input  csre_pkg::tower_t          twr,
  input  csre_pkg::tower_t          seed,
  input  logic [csre_pkg::RN_W-1:0] rings,
  input  logic [RIW-1:0]            rd_addr,
  output csre_pkg::acc_t            rd_data,
  output logic                      busy
);
  import csre_pkg::*;

  logic [ETA_W-1:0]  de;
  logic [PHI_W-1:0]  dp;
  logic [PHI_W:0]    dpw;
  logic [DIST_W-1:0] dphi;
  logic [DIST_W-1:0] ring_d;
  logic              hit;
  logic              ram_re;
  logic [RIW-1:0]    ram_raddr;
  acc_t              ram_q;

  logic              s2_v_r;
  logic [RIW-1:0]    s2_addr_r;
  logic [EN_W-1:0]   s2_en_r;
  logic              rvld_r;
  logic              w_v_r;
  logic [RIW-1:0]    w_addr_r;
  acc_t              w_data_r;
  logic [MAX_RINGS-1:0] vld_r;

  acc_t              base;
  acc_t              upd;
  logic [SUM_W:0]    esum;

  // chebyshev grid distance with phi wrap
  always_comb begin
    de     = (twr.eta > seed.eta) ? (twr.eta - seed.eta) : (seed.eta - twr.eta);
    dp     = (twr.phi > seed.phi) ? (twr.phi - seed.phi) : (seed.phi - twr.phi);
    dpw    = (PHI_W+1)'(PHI_BINS) - {1'b0, dp};
    dphi   = (dpw < {1'b0, dp}) ? dpw[DIST_W-1:0] : dp;
    ring_d = ({1'b0, de} > dphi) ? DIST_W'(de) : dphi;
    hit    = ctl.twr_v && (ring_d < DIST_W'(rings));
  end

  assign ram_re    = hit || ctl.rd_en;
  assign ram_raddr = hit ? ring_d[RIW-1:0] : rd_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      w_v_r  <= 1'b0;
      vld_r  <= '0;
    end else begin
      s2_v_r <= hit;
      w_v_r  <= s2_v_r && !ctl.clear;
      if (ctl.clear) begin
        vld_r <= '0;
      end else if (s2_v_r) begin
        vld_r[s2_addr_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      rvld_r <= vld_r[ram_raddr];
    end
    s2_addr_r <= ram_raddr;
    s2_en_r   <= twr.energy;
    w_addr_r  <= s2_addr_r;
    w_data_r  <= upd;
  end

  // forward the previous write when it hits the entry just read
  always_comb begin
    if (w_v_r && (w_addr_r == s2_addr_r)) begin
      base = w_data_r;
    end else if (rvld_r) begin
      base = ram_q;
    end else begin
      base = '0;
    end
    esum       = {1'b0, base.energy} + (SUM_W+1)'(s2_en_r);
    upd.energy = esum[SUM_W] ? SUM_MAX : esum[SUM_W-1:0];
    upd.count  = (base.count == CNT_MAX) ? CNT_MAX : base.count + CNT_W'(1);
  end

  csre_ram #(
    .WIDTH ($bits(acc_t)),
    .DEPTH (MAX_RINGS),
    .AW    (RIW)
  ) u_acc_ram (
    .clk   (clk),
    .we    (s2_v_r),
    .waddr (s2_addr_r),
    .wdata (upd),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  assign rd_data = rvld_r ? ram_q : '0;
  assign busy    = s2_v_r;

  a_no_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.twr_v && ctl.rd_en))
    else $error("tower update and result read share the accumulator port");

  a_no_clear_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clear |-> !s2_v_r && !ctl.twr_v)
    else $error("accumulator clear while an update is in flight");

  a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && !ctl.clear |=> vld_r[$past(s2_addr_r)])
    else $error("written accumulator entry not marked valid");

endmodule

/* src/calo_seed_ring_energy_sum_unit.sv */
// top level of the seed tower ring energy sum unit
//
//  port group   dir   handshake          payload
//  in_if        sink  valid/ready        eta_index, phi_index, tower_energy, is_last
//  out_if       src   valid/ready        ring_number .. last_ring, one per ring
//  psel..prdata apb   setup + access     ring_count at byte 0
//
// a tower is written to the tower memory while it has room; the seed is tracked on the fly
// the last tower starts a scan of the tower memory when a seed was found, one read a cycle
// each ring result then takes an accumulator read, then an output load that waits out stalls
// reset leaves the tower memory unwritten; accumulator entries carry valid flops, no clearing pass
// no tower is taken from the last tower until the last ring result sits in the output register
module calo_seed_ring_energy_sum_unit #(
  parameter int MAX_TOWERS = 1024,
  parameter int MAX_RINGS  = 30
) (
  input  logic                        clk,
  input  logic                        rst_n,
  csre_in_if.sink                     in_if,
  csre_out_if.source                  out_if,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [csre_pkg::CFG_AW-1:0] paddr,
  input  logic [csre_pkg::CFG_DW-1:0] pwdata,
  output logic [csre_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import csre_pkg::*;

  localparam int TAW  = $clog2(MAX_TOWERS);
  localparam int CW   = $clog2(MAX_TOWERS + 1);
  localparam int RIW  = (MAX_RINGS > 1) ? $clog2(MAX_RINGS) : 1;
  localparam int RMAX = (MAX_RINGS > 31) ? 31 : MAX_RINGS;

  typedef enum logic [4:0] {
    ST_LOAD  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_ORD   = 5'b01000,
    ST_OLD   = 5'b10000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [TAW-1:0]  i_r, i_nxt;
  logic            tv_r;
  tower_t          seed_r, seed_nxt;
  logic [RN_W-1:0] n_r, n_nxt;
  logic [SUM_W-1:0] cum_r, cum_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [RN_W-1:0]  o_ring_r;
  logic [SUM_W-1:0] o_energy_r;
  logic [SUM_W-1:0] o_square_r;
  logic [CNT_W-1:0] o_count_r;
  logic             o_found_r;
  logic             o_last_r;

  logic [RN_W-1:0]  ring_count;
  logic [RN_W-1:0]  rings;
  logic             in_acc;
  logic             store;
  logic             first;
  logic [EN_W-1:0]  cur_e;
  tower_t           tower_in;
  tower_t           twr_q;
  acc_ctl_t         ctl;
  acc_t             rd_data;
  logic             busy;
  logic             slot_free;
  logic             load_out;
  logic             is_last_ring;
  logic [SUM_W:0]   csum;

  csre_apb_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .ring_count (ring_count)
  );

  always_comb begin
    if (ring_count == '0) begin
      rings = RN_W'(1);
    end else if (ring_count > RN_W'(RMAX)) begin
      rings = RN_W'(RMAX);
    end else begin
      rings = ring_count;
    end
  end

  assign in_if.ready = (state_r == ST_LOAD);
  assign in_acc      = in_if.valid && in_if.ready;
  assign store       = in_acc && (cnt_r < CW'(MAX_TOWERS));
  assign first       = (cnt_r == '0);
  assign cur_e       = first ? '0 : seed_r.energy;
  assign tower_in    = '{eta: in_if.eta_index, phi: in_if.phi_index, energy: in_if.tower_energy};

  // seed is the first strictly largest energy above zero
  always_comb begin
    seed_nxt = seed_r;
    if (store && (in_if.tower_energy > cur_e)) begin
      seed_nxt = tower_in;
    end else if (in_acc && first) begin
      seed_nxt = '0;
    end
  end

  csre_ram #(
    .WIDTH ($bits(tower_t)),
    .DEPTH (MAX_TOWERS),
    .AW    (TAW)
  ) u_tower_ram (
    .clk   (clk),
    .we    (store),
    .waddr (cnt_r[TAW-1:0]),
    .wdata (tower_in),
    .re    (state_r == ST_SCAN),
    .raddr (i_r),
    .rdata (twr_q)
  );

  assign ctl.twr_v = tv_r;
  assign ctl.rd_en = (state_r == ST_ORD);
  assign ctl.clear = in_acc && in_if.is_last;

  csre_ring_acc #(
    .MAX_RINGS (MAX_RINGS),
    .RIW       (RIW)
  ) u_ring_acc (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .twr     (twr_q),
    .seed    (seed_r),
    .rings   (rings),
    .rd_addr (RIW'(n_r)),
    .rd_data (rd_data),
    .busy    (busy)
  );

  assign slot_free    = !out_valid_r || out_if.ready;
  assign load_out     = (state_r == ST_OLD) && slot_free;
  assign is_last_ring = (n_r == rings - RN_W'(1));
  assign csum         = {1'b0, cum_r} + {1'b0, rd_data.energy};

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    n_nxt         = n_r;
    cum_nxt       = cum_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    case (state_r)
      ST_LOAD: begin
        if (store) begin
          cnt_nxt = cnt_r + CW'(1);
        end
        if (in_acc && in_if.is_last) begin
          i_nxt = '0;
          n_nxt = '0;
          cum_nxt = '0;
          if (seed_nxt.energy != '0) begin
            state_nxt = ST_SCAN;
          end else begin
            cnt_nxt   = '0;
            state_nxt = ST_ORD;
          end
        end
      end
      ST_SCAN: begin
        i_nxt = i_r + TAW'(1);
        if ((CW'(i_r) + CW'(1)) == cnt_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!tv_r && !busy) begin
          cnt_nxt   = '0;
          state_nxt = ST_ORD;
        end
      end
      ST_ORD: begin
        state_nxt = ST_OLD;
      end
      ST_OLD: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          cum_nxt       = csum[SUM_W] ? SUM_MAX : csum[SUM_W-1:0];
          n_nxt         = n_r + RN_W'(1);
          state_nxt     = is_last_ring ? ST_LOAD : ST_ORD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      tv_r        <= 1'b0;
      seed_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      tv_r        <= (state_r == ST_SCAN);
      seed_r      <= seed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r   <= i_nxt;
    n_r   <= n_nxt;
    cum_r <= cum_nxt;
    if (load_out) begin
      o_ring_r   <= n_r;
      o_energy_r <= rd_data.energy;
      o_square_r <= cum_nxt;
      o_count_r  <= rd_data.count;
      o_found_r  <= (seed_r.energy != '0);
      o_last_r   <= is_last_ring;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.ring_number    = o_ring_r;
  assign out_if.ring_energy    = o_energy_r;
  assign out_if.square_energy  = o_square_r;
  assign out_if.towers_in_ring = o_count_r;
  assign out_if.seed_found     = o_found_r;
  assign out_if.last_ring      = o_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_TOWERS))
    else $error("tower count beyond memory depth");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (CW'(i_r) < cnt_r))
    else $error("scan reads past the stored towers");

  a_read_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ORD) |-> !busy && !tv_r)
    else $error("ring read while accumulator updates are in flight");

  a_last_ends_event: assert property (@(posedge clk) disable iff (!rst_n)
    load_out && is_last_ring |=> (state_r == ST_LOAD) && (cnt_r == '0))
    else $error("event not closed after the final ring");

endmodule

/* tb/calo_seed_ring_energy_sum_unit_test.sv */
// self-checking testbench for the calorimeter seed tower ring energy sum unit
`timescale 1ns / 1ps

module calo_seed_ring_energy_sum_unit_test;
  import csre_pkg::*;

  localparam int TOWER_SLOTS  = 1024;
  localparam int RING_SLOTS   = 30;
  localparam int SETTLE_TICKS = 16;
  localparam int RANDOM_ITEMS = 320;
  localparam longint SUM_LIMIT = (longint'(1) << SUM_W) - 1;
  localparam int CNT_LIMIT = (1 << CNT_W) - 1;

  typedef struct {
    tower_t tower;
    logic   is_last;
  } tower_req_t;

  typedef struct {
    logic [RN_W-1:0]  ring_number;
    logic [SUM_W-1:0] ring_energy;
    logic [SUM_W-1:0] square_energy;
    logic [CNT_W-1:0] towers_in_ring;
    logic             seed_found;
    logic             last_ring;
  } ring_result_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  csre_in_if  tower_ch ();
  csre_out_if ring_ch ();

  calo_seed_ring_energy_sum_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (tower_ch),
    .out_if (ring_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  tower_req_t      tower_requests[$];
  tower_t          event_towers[$];
  ring_result_t    ring_expect[$];
  tower_req_t      next_req;
  ring_result_t    oldest_ring;
  logic [RN_W-1:0] ring_setting;
  int              idle_pct;
  int              mismatch_count;
  int              random_items;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report(string what, longint got, longint want);
    if (mismatch_count < 40) begin
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    end
    mismatch_count++;
  endtask

  function automatic int grid_distance(tower_t t, logic [ETA_W-1:0] e, logic [PHI_W-1:0] p);
    int de;
    int dp;
    de = int'(t.eta) - int'(e);
    if (de < 0) de = -de;
    dp = int'(t.phi) - int'(p);
    if (dp < 0) dp = -dp;
    if (PHI_BINS - dp < dp) dp = PHI_BINS - dp;
    return (de > dp) ? de : dp;
  endfunction

  task automatic close_event();
    logic [EN_W-1:0]  best_energy;
    logic [ETA_W-1:0] seed_eta;
    logic [PHI_W-1:0] seed_phi;
    logic             found;
    int               rings;
    int               ring_d;
    longint           cum;
    longint           ring_sum[RING_SLOTS];
    int               ring_cnt[RING_SLOTS];
    ring_result_t     r;
    best_energy = '0;
    seed_eta = '0;
    seed_phi = '0;
    found = 1'b0;
    foreach (event_towers[i]) begin
      if (event_towers[i].energy > best_energy) begin
        best_energy = event_towers[i].energy;
        seed_eta = event_towers[i].eta;
        seed_phi = event_towers[i].phi;
        found = 1'b1;
      end
    end
    rings = (ring_setting == 0) ? 1 : (ring_setting > RING_SLOTS) ? RING_SLOTS : ring_setting;
    for (int n = 0; n < RING_SLOTS; n++) begin
      ring_sum[n] = 0;
      ring_cnt[n] = 0;
    end
    if (found) begin
      foreach (event_towers[i]) begin
        ring_d = grid_distance(event_towers[i], seed_eta, seed_phi);
        if (ring_d < rings) begin
          ring_sum[ring_d] += event_towers[i].energy;
          if (ring_sum[ring_d] > SUM_LIMIT) ring_sum[ring_d] = SUM_LIMIT;
          if (ring_cnt[ring_d] < CNT_LIMIT) ring_cnt[ring_d]++;
        end
      end
    end
    cum = 0;
    for (int n = 0; n < rings; n++) begin
      cum += ring_sum[n];
      if (cum > SUM_LIMIT) cum = SUM_LIMIT;
      r.ring_number    = RN_W'(n);
      r.ring_energy    = SUM_W'(ring_sum[n]);
      r.square_energy  = SUM_W'(cum);
      r.towers_in_ring = CNT_W'(ring_cnt[n]);
      r.seed_found     = found;
      r.last_ring      = (n + 1 == rings);
      ring_expect.push_back(r);
    end
    event_towers.delete();
  endtask

  task automatic take_tower(tower_t t, logic is_last);
    if (event_towers.size() < TOWER_SLOTS) event_towers.push_back(t);
    if (is_last) close_event();
  endtask

  // tower request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      tower_ch.valid <= 1'b0;
    end else if (!tower_ch.valid || tower_ch.ready) begin
      if (tower_requests.size() > 0 && $urandom_range(99) >= idle_pct) begin
        next_req = tower_requests.pop_front();
        tower_ch.valid        <= 1'b1;
        tower_ch.eta_index    <= next_req.tower.eta;
        tower_ch.phi_index    <= next_req.tower.phi;
        tower_ch.tower_energy <= next_req.tower.energy;
        tower_ch.is_last      <= next_req.is_last;
      end else begin
        tower_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && tower_ch.valid && tower_ch.ready) begin
      take_tower('{eta: tower_ch.eta_index, phi: tower_ch.phi_index,
                   energy: tower_ch.tower_energy}, tower_ch.is_last);
    end
  end

  // ring result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      ring_ch.ready <= 1'b0;
    end else begin
      if (ring_ch.valid && ring_ch.ready) begin
        if (ring_expect.size() == 0) begin
          report("ring result with none expected", ring_ch.ring_number, 0);
        end else begin
          oldest_ring = ring_expect.pop_front();
          if (ring_ch.ring_number !== oldest_ring.ring_number)
            report("ring_number", ring_ch.ring_number, oldest_ring.ring_number);
          if (ring_ch.ring_energy !== oldest_ring.ring_energy)
            report("ring_energy", ring_ch.ring_energy, oldest_ring.ring_energy);
          if (ring_ch.square_energy !== oldest_ring.square_energy)
            report("square_energy", ring_ch.square_energy, oldest_ring.square_energy);
          if (ring_ch.towers_in_ring !== oldest_ring.towers_in_ring)
            report("towers_in_ring", ring_ch.towers_in_ring, oldest_ring.towers_in_ring);
          if (ring_ch.seed_found !== oldest_ring.seed_found)
            report("seed_found", ring_ch.seed_found, oldest_ring.seed_found);
          if (ring_ch.last_ring !== oldest_ring.last_ring)
            report("last_ring", ring_ch.last_ring, oldest_ring.last_ring);
        end
      end
      ring_ch.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  task automatic push_tower(int eta, int phi, int energy, logic is_last);
    tower_req_t req;
    req.tower.eta    = ETA_W'(eta);
    req.tower.phi    = PHI_W'(phi);
    req.tower.energy = EN_W'(energy);
    req.is_last      = is_last;
    tower_requests.push_back(req);
  endtask

  task automatic random_event();
    int n;
    int ce;
    int cp;
    int spread;
    int energy;
    n = ($urandom_range(9) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 1);
    ce = ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(95);
    cp = $urandom_range(255);
    spread = $urandom_range(1) ? 4 : 34;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(5))
        0: energy = 0;
        1: energy = $urandom_range(15);
        2: energy = 20'hFFFFF;
        3: energy = $urandom_range(5000);
        default: energy = $urandom & 20'hFFFFF;
      endcase
      push_tower(ce + int'($urandom_range(2 * spread)) - spread,
                 cp + int'($urandom_range(2 * spread)) - spread, energy, k == n - 1);
      random_items++;
    end
  endtask

  task automatic drain();
    while (tower_requests.size() != 0 || tower_ch.valid || ring_expect.size() != 0)
      @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_ring_count(logic [RN_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(int'(REG_RING_COUNT) * 4);
    pwdata  <= CFG_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    ring_setting = value;
  endtask

  initial begin
    logic [RN_W-1:0] phase_setting;
    int phase;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tower_ch.valid = 1'b0;
    tower_ch.eta_index = '0;
    tower_ch.phi_index = '0;
    tower_ch.tower_energy = '0;
    tower_ch.is_last = 1'b0;
    ring_ch.ready = 1'b0;
    idle_pct = 22;
    mismatch_count = 0;
    random_items = 0;
    ring_setting = RING_COUNT_RST;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // no seed at all
    push_tower(0, 0, 0, 1'b1);
    // equal maxima, corners and phi wrap
    push_tower(127, 255, 20'hFFFFF, 1'b0);
    push_tower(0, 0, 20'hFFFFF, 1'b0);
    push_tower(95, 128, 1, 1'b0);
    push_tower(126, 0, 3, 1'b0);
    push_tower(0, 1, 0, 1'b0);
    push_tower(127, 254, 9, 1'b1);
    // ties, zero energy towers and the half-turn phi distance
    push_tower(10, 5, 100, 1'b0);
    push_tower(10, 5, 100, 1'b0);
    push_tower(12, 250, 0, 1'b0);
    push_tower(40, 5, 50, 1'b0);
    push_tower(10, 133, 20, 1'b1);
    drain();
    write_ring_count(1);
    push_tower(50, 100, 20'hFFFFF, 1'b0);
    push_tower(50, 101, 7, 1'b0);
    push_tower(51, 100, 2, 1'b1);
    drain();
    write_ring_count(0);
    push_tower(3, 3, 0, 1'b0);
    push_tower(3, 3, 1, 1'b1);
    drain();
    write_ring_count(31);
    push_tower(96, 7, 12345, 1'b1);

    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      drain();
      case (phase)
        0: phase_setting = 30;
        1: phase_setting = 1;
        2: phase_setting = 0;
        3: phase_setting = 31;
        default: phase_setting = RN_W'($urandom_range(31));
      endcase
      write_ring_count(phase_setting);
      idle_pct = (phase == 4) ? 0 : 22;
      for (int ev = 0; ev < 6; ev++) begin
        random_event();
        if (phase == 2) drain();
      end
      phase++;
    end
    drain();
    idle_pct = 22;
    repeat (40) @(posedge clk);
    if (ring_expect.size() != 0) report("ring results never delivered", ring_expect.size(), 0);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* sim.f */
src/csre_pkg.sv
src/csre_if.sv
src/csre_ram.sv
src/csre_apb_regs.sv
src/csre_ring_acc.sv
src/calo_seed_ring_energy_sum_unit.sv
tb/calo_seed_ring_energy_sum_unit_test.sv
